[rtl/core/csvcan_pkg.sv]
package csvcan_pkg;

  localparam int MAX_SEPARATORS = 16;
  localparam int CNT_W = $clog2(MAX_SEPARATORS + 1);
  localparam logic [CNT_W-1:0] MIN_FIELDS_SEPS = CNT_W'(5);
  localparam logic [CNT_W-1:0] LEN_FIELD = CNT_W'(5);
  localparam logic [CNT_W-1:0] FLAG_FIELD = CNT_W'(2);
  localparam logic [CNT_W-1:0] DATA_FIELD0 = CNT_W'(6);
  localparam int NUM_BYTES = 8;

  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_COMMA = 8'd44;

  localparam logic [1:0] PH_SKIP = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;
  localparam logic [1:0] PH_ZERO = 2'd3;

  localparam logic [2:0] FL_IDLE = 3'd0;
  localparam logic [2:0] FL_T = 3'd1;
  localparam logic [2:0] FL_TR = 3'd2;
  localparam logic [2:0] FL_TRU = 3'd3;
  localparam logic [2:0] FL_TRUE = 3'd4;
  localparam logic [2:0] FL_ONE = 3'd5;
  localparam logic [2:0] FL_FAIL = 3'd7;

  localparam logic [2:0] HD_IDLE = 3'd0;
  localparam logic [2:0] HD_MATCH = 3'd4;
  localparam logic [2:0] HD_FAIL = 3'd7;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [1:0] ph;
    logic [31:0] acc;
    logic [31:0] tm;
    logic [31:0] id;
    logic [2:0] flg;
    logic [3:0] len;
    logic [63:0] byt;
  } par_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [4:0] digit_val(input logic [7:0] c, input logic hex);
    logic [4:0] d;
    d = 5'h10;
    if (c >= "0" && c <= "9") d = 5'(c - "0");
    else if (hex && c >= "a" && c <= "f") d = 5'(c - "a" + 8'd10);
    else if (hex && c >= "A" && c <= "F") d = 5'(c - "A" + 8'd10);
    return d;
  endfunction

  function automatic par_t scan_feed(input par_t s, input logic [7:0] c, input logic hex);
    par_t r;
    logic [4:0] d;
    logic [35:0] v;
    r = s;
    d = digit_val(c, hex);
    if (hex) v = {s.acc, 4'b0} + 36'(d[3:0]);
    else v = {1'b0, s.acc, 3'b0} + {3'b0, s.acc, 1'b0} + 36'(d[3:0]);
    if (s.ph == PH_DONE) begin
      r = s;
    end else if (s.ph == PH_SKIP && is_ws(c)) begin
      r = s;
    end else if (s.ph == PH_SKIP && (c == "+" || c == "-")) begin
      r.ph = PH_DONE;
    end else if (s.ph == PH_ZERO && (c == "x" || c == "X")) begin
      r.ph = PH_DIGITS;
    end else if (d[4]) begin
      r.ph = PH_DONE;
    end else if (hex && s.ph == PH_SKIP && d == 5'd0) begin
      r.acc = '0;
      r.ph = PH_ZERO;
    end else begin
      r.acc = (v[35:32] != 4'd0) ? 32'hFFFF_FFFF : v[31:0];
      r.ph = PH_DIGITS;
    end
    return r;
  endfunction

  function automatic par_t field_finish(input par_t s);
    par_t r;
    r = s;
    if (s.cnt == CNT_W'(0)) r.tm = s.acc;
    else if (s.cnt == CNT_W'(1)) r.id = s.acc;
    else if (s.cnt == LEN_FIELD) r.len = (s.acc > 32'd8) ? 4'd8 : s.acc[3:0];
    for (int i = 0; i < NUM_BYTES; i++) begin
      if (s.cnt == DATA_FIELD0 + CNT_W'(i)) r.byt[8*i +: 8] = s.byt[8*i +: 8] | s.acc[7:0];
    end
    return r;
  endfunction

  function automatic logic [2:0] flag_feed(input logic [2:0] s, input logic [7:0] c);
    logic [7:0] u;
    logic [2:0] n;
    u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    n = FL_FAIL;
    if (s == FL_IDLE) n = (u == "T") ? FL_T : ((c == "1") ? FL_ONE : FL_FAIL);
    else if (s == FL_T && u == "R") n = FL_TR;
    else if (s == FL_TR && u == "U") n = FL_TRU;
    else if (s == FL_TRU && u == "E") n = FL_TRUE;
    return n;
  endfunction

  function automatic par_t parser_feed(input par_t s, input logic [7:0] c, input logic tab);
    par_t r;
    logic [7:0] sep;
    r = s;
    sep = tab ? CH_TAB : CH_COMMA;
    if (c == sep) begin
      r = field_finish(s);
      if (s.cnt < CNT_W'(MAX_SEPARATORS)) r.cnt = s.cnt + CNT_W'(1);
      r.ph = PH_SKIP;
      r.acc = '0;
    end else if (s.cnt == FLAG_FIELD) begin
      r.flg = flag_feed(s.flg, c);
    end else if (s.cnt == CNT_W'(1) ||
                 (s.cnt >= DATA_FIELD0 && s.cnt <= DATA_FIELD0 + CNT_W'(NUM_BYTES - 1))) begin
      r = scan_feed(s, c, 1'b1);
    end else if (s.cnt == CNT_W'(0) || s.cnt == LEN_FIELD) begin
      r = scan_feed(s, c, 1'b0);
    end
    return r;
  endfunction

  function automatic logic [2:0] header_feed(input logic [2:0] s, input logic [7:0] c);
    logic [2:0] n;
    n = s;
    if (s == HD_MATCH || s == HD_FAIL) n = s;
    else if (s == 3'd0) n = (c == "T" || c == "t") ? 3'd1 : HD_FAIL;
    else if (s == 3'd1) n = (c == "i") ? 3'd2 : HD_FAIL;
    else if (s == 3'd2) n = (c == "m") ? 3'd3 : HD_FAIL;
    else n = (c == "e") ? HD_MATCH : HD_FAIL;
    return n;
  endfunction

endpackage

[rtl/core/csv_can_frame_parser_top.sv]
// CAN log line parser: one text byte per beat on the input stream, one frame
// beat per non-empty, non-header line on the output stream. A byte is
// accepted in every cycle unless a finished frame is held in the output
// register and not taken. Comma and tab splitting run in two
// parallel field scanners; the choice is made at line end (LF or tlast).
// tuser = 1 flags a line with fewer than five separators, all data then zero.
module csv_can_frame_parser_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] text_char
  input  logic         in_tlast,   // end_of_input
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // [31:0] timestamp, [63:32] can_id, [64] extended,
                                   // [68:65] length, [132:69] data_bytes, rest zero
  output logic         out_tuser   // status
);
  import csvcan_pkg::*;

  logic content_r, content_nxt;
  logic [2:0] hdr_r, hdr_nxt;
  logic tpend_r, tpend_nxt;
  logic tfound_r, tfound_nxt;
  logic [CNT_W-1:0] ctabs_r, ctabs_nxt;
  par_t pc_r, pc_nxt, pt_r, pt_nxt;
  logic ov_r, ov_nxt;
  logic [135:0] od_r, od_nxt;
  logic ou_r, ou_nxt;

  logic acc_in;
  logic [7:0] c;
  logic ws, take, eol;
  par_t pc_f, pt_f, sel;
  logic [CNT_W-1:0] cnt;
  logic [63:0] data;

  assign in_tready = !ov_r || out_tready;
  assign acc_in = in_tvalid && in_tready;
  assign c = in_tdata;
  assign out_tvalid = ov_r;
  assign out_tdata = od_r;
  assign out_tuser = ou_r;

  always_comb begin
    ws = is_ws(c);
    take = (c != CH_LF) && (content_r || !ws);
    eol = (c == CH_LF) || in_tlast;
    content_nxt = content_r;
    hdr_nxt = hdr_r;
    tpend_nxt = tpend_r;
    tfound_nxt = tfound_r;
    ctabs_nxt = ctabs_r;
    pc_nxt = pc_r;
    pt_nxt = pt_r;
    ov_nxt = ov_r && !out_tready;
    od_nxt = od_r;
    ou_nxt = ou_r;
    if (acc_in && take) begin
      if (!ws) content_nxt = 1'b1;
      hdr_nxt = header_feed(hdr_r, c);
      pc_nxt = parser_feed(pc_r, c, 1'b0);
      pt_nxt = parser_feed(pt_r, c, 1'b1);
      if (c == CH_TAB) begin
        tpend_nxt = 1'b1;
      end else if (!ws) begin
        if (tpend_r) tfound_nxt = 1'b1;
        tpend_nxt = 1'b0;
        ctabs_nxt = pt_nxt.cnt;
      end
    end
    pc_f = field_finish(pc_nxt);
    pt_f = field_finish(pt_nxt);
    sel = tfound_nxt ? pt_f : pc_f;
    cnt = tfound_nxt ? ctabs_nxt : pc_nxt.cnt;
    data = sel.byt;
    for (int i = 0; i < NUM_BYTES; i++) begin
      if (4'(i) >= sel.len) data[8*i +: 8] = 8'd0;
    end
    if (acc_in && eol) begin
      if (content_nxt && hdr_nxt != HD_MATCH) begin
        ov_nxt = 1'b1;
        if (cnt < MIN_FIELDS_SEPS) begin
          ou_nxt = 1'b1;
          od_nxt = '0;
        end else begin
          ou_nxt = 1'b0;
          od_nxt = {3'b0, data, sel.len, (sel.flg == FL_TRUE || sel.flg == FL_ONE),
                    sel.id, sel.tm};
        end
      end
      content_nxt = 1'b0;
      hdr_nxt = HD_IDLE;
      tpend_nxt = 1'b0;
      tfound_nxt = 1'b0;
      ctabs_nxt = '0;
      pc_nxt = '0;
      pt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      content_r <= 1'b0;
      hdr_r <= HD_IDLE;
      tpend_r <= 1'b0;
      tfound_r <= 1'b0;
      ctabs_r <= '0;
      pc_r <= '0;
      pt_r <= '0;
      ov_r <= 1'b0;
    end else begin
      content_r <= content_nxt;
      hdr_r <= hdr_nxt;
      tpend_r <= tpend_nxt;
      tfound_r <= tfound_nxt;
      ctabs_r <= ctabs_nxt;
      pc_r <= pc_nxt;
      pt_r <= pt_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    od_r <= od_nxt;
    ou_r <= ou_nxt;
  end

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0) else $error("error beat carries data");
  a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[68:65] <= 4'd8) else $error("length above 8");
  a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
    acc_in && (in_tdata == CH_LF || in_tlast) |=> !content_r && pc_r == '0 && pt_r == '0)
    else $error("line state not cleared");
`endif

endmodule

[test/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        err;
    logic [31:0] stamp;
    logic [31:0] ident;
    logic        ext;
    logic [3:0]  len;
    logic [63:0] data;
  } frame_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_beat_t;

  typedef struct {
    logic [4:0]  cnt;
    logic [1:0]  ph;
    logic [31:0] acc;
    logic [31:0] tm;
    logic [31:0] id;
    logic [2:0]  flg;
    logic [3:0]  len;
    logic [63:0] byt;
  } split_t;

  localparam int SEP_LIMIT = 16;
  localparam logic [1:0] SCAN_SKIP = 2'd0, SCAN_DIGITS = 2'd1, SCAN_DONE = 2'd2,
                         SCAN_ZERO = 2'd3;
  localparam logic [2:0] FLAG_IDLE = 3'd0, FLAG_T = 3'd1, FLAG_TR = 3'd2,
                         FLAG_TRU = 3'd3, FLAG_TRUE = 3'd4, FLAG_ONE = 3'd5,
                         FLAG_FAIL = 3'd7;
  localparam logic [2:0] HDR_MATCH = 3'd4, HDR_FAIL = 3'd7;
  localparam logic [7:0] LF = 8'd10, TAB = 8'd9, COMMA = 8'd44;
  localparam int LIMIT = 400000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic in_tlast = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [135:0] out_tdata;
  logic out_tuser;

  csv_can_frame_parser_top i_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  text_beat_t text_q[$];
  frame_t frames_due[$];
  int failures = 0;
  bit feeding_done = 0;
  bit calm = 0;
  bit hold_off = 0;

  // line parser state
  logic       seen;
  logic [2:0] hdr;
  logic       tab_pend, tab_hit;
  logic [4:0] tab_commit;
  split_t     sp[2];

  function automatic bit ws(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic int digit(logic [7:0] c, bit hex);
    if (c >= "0" && c <= "9") return c - "0";
    if (hex && c >= "a" && c <= "f") return c - "a" + 10;
    if (hex && c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic split_t scan_num(split_t s, logic [7:0] c, bit hex);
    int d;
    logic [63:0] v;
    if (s.ph == SCAN_DONE) return s;
    if (s.ph == SCAN_SKIP) begin
      if (ws(c)) return s;
      if (c == "+" || c == "-") begin s.ph = SCAN_DONE; return s; end
    end
    if (s.ph == SCAN_ZERO && (c == "x" || c == "X")) begin
      s.ph = SCAN_DIGITS;
      return s;
    end
    d = digit(c, hex);
    if (d < 0) begin s.ph = SCAN_DONE; return s; end
    if (hex && s.ph == SCAN_SKIP && d == 0) begin
      s.acc = 0;
      s.ph = SCAN_ZERO;
      return s;
    end
    v = 64'(s.acc) * (hex ? 16 : 10) + d;
    s.acc = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    s.ph = SCAN_DIGITS;
    return s;
  endfunction

  function automatic split_t close_field(split_t s);
    if (s.cnt == 0) s.tm = s.acc;
    else if (s.cnt == 1) s.id = s.acc;
    else if (s.cnt == 5) s.len = (s.acc > 8) ? 4'd8 : s.acc[3:0];
    else if (s.cnt >= 6 && s.cnt <= 13) s.byt[8*(s.cnt-6) +: 8] |= s.acc[7:0];
    return s;
  endfunction

  function automatic logic [2:0] flag_step(logic [2:0] s, logic [7:0] c);
    logic [7:0] u;
    u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    if (s == FLAG_IDLE) return (u == "T") ? FLAG_T : (c == "1" ? FLAG_ONE : FLAG_FAIL);
    if (s == FLAG_T && u == "R") return FLAG_TR;
    if (s == FLAG_TR && u == "U") return FLAG_TRU;
    if (s == FLAG_TRU && u == "E") return FLAG_TRUE;
    return FLAG_FAIL;
  endfunction

  function automatic split_t split_feed(split_t s, logic [7:0] c, logic [7:0] sep);
    if (c == sep) begin
      s = close_field(s);
      if (s.cnt < SEP_LIMIT) s.cnt++;
      s.ph = SCAN_SKIP;
      s.acc = 0;
    end else if (s.cnt == 2) s.flg = flag_step(s.flg, c);
    else if (s.cnt == 1 || (s.cnt >= 6 && s.cnt <= 13)) s = scan_num(s, c, 1);
    else if (s.cnt == 0 || s.cnt == 5) s = scan_num(s, c, 0);
    return s;
  endfunction

  task automatic clear_line();
    seen = 0; hdr = 0; tab_pend = 0; tab_hit = 0; tab_commit = 0;
    for (int p = 0; p < 2; p++) sp[p] = '{default: '0};
  endtask

  task automatic predict_byte(logic [7:0] c, logic last);
    frame_t f;
    int p;
    logic [4:0] cnt;
    if (c != LF && (seen || !ws(c))) begin
      if (!ws(c)) seen = 1;
      if (hdr != HDR_MATCH && hdr != HDR_FAIL) begin
        case (hdr)
          3'd0: hdr = (c == "T" || c == "t") ? 3'd1 : HDR_FAIL;
          3'd1: hdr = (c == "i") ? 3'd2 : HDR_FAIL;
          3'd2: hdr = (c == "m") ? 3'd3 : HDR_FAIL;
          default: hdr = (c == "e") ? HDR_MATCH : HDR_FAIL;
        endcase
      end
      sp[0] = split_feed(sp[0], c, COMMA);
      sp[1] = split_feed(sp[1], c, TAB);
      if (c == TAB) tab_pend = 1;
      else if (!ws(c)) begin
        if (tab_pend) tab_hit = 1;
        tab_pend = 0;
        tab_commit = sp[1].cnt;
      end
    end
    if (c == LF || last) begin
      if (seen && hdr != HDR_MATCH) begin
        p = tab_hit;
        cnt = p ? tab_commit : sp[0].cnt;
        sp[0] = close_field(sp[0]);
        sp[1] = close_field(sp[1]);
        f = '0;
        if (cnt < 5) f.err = 1;
        else begin
          f.stamp = sp[p].tm;
          f.ident = sp[p].id;
          f.ext = sp[p].flg == FLAG_TRUE || sp[p].flg == FLAG_ONE;
          f.len = sp[p].len;
          f.data = sp[p].byt;
          if (f.len < 8) f.data &= (64'd1 << (8 * f.len)) - 1;
        end
        frames_due.push_back(f);
      end
      clear_line();
    end
  endtask

  // stimulus generation
  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back('{s[i], 1'b0});
  endtask

  function automatic string rnd_ws();
    string s;
    s = "";
    repeat ($urandom_range(0, 2)) s = {s, string'(byte'($urandom_range(0, 3) == 0 ? 9 :
      ($urandom_range(0, 1) ? 32 : $urandom_range(11, 13))))};
    return s;
  endfunction

  function automatic string rnd_num(bit hex);
    string s;
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return "";
    if (k == 1) return $sformatf("%s%0d", $urandom_range(0, 1) ? "+" : "-", $urandom_range(0, 99));
    if (k == 2) begin
      s = "";
      repeat ($urandom_range(9, 14)) s = {s, hex ? "F" : "9"};
      return s;
    end
    if (hex) begin
      if (k == 3) return $sformatf("0%s%0h", $urandom_range(0, 1) ? "x" : "X", $urandom);
      if (k == 4) return $sformatf("%0H", $urandom);
      return $sformatf("%0h", $urandom_range(0, 511));
    end
    if (k == 3) return $sformatf("%0d", $urandom);
    if (k == 4) return $sformatf("%0da", $urandom_range(0, 12));
    return $sformatf("%0d", $urandom_range(0, 12));
  endfunction

  function automatic string rnd_flag();
    case ($urandom_range(0, 6))
      0: return "TRUE";
      1: return "true";
      2: return "1";
      3: return "FALSE";
      4: return "TrUe";
      5: return "TRUEx";
      default: return "0";
    endcase
  endfunction

  function automatic string rnd_line();
    string s, sep, f;
    int nf;
    if ($urandom_range(0, 9) == 0) begin
      s = "";
      repeat ($urandom_range(1, 12)) s = {s, string'(byte'($urandom_range(1, 255) == 10 ?
        65 : $urandom_range(1, 255)))};
      return s;
    end
    if ($urandom_range(0, 19) == 0) return $urandom_range(0, 1) ? "Time,ID" : "time\tx";
    sep = $urandom_range(0, 2) == 0 ? "\t" : ",";
    nf = $urandom_range(0, 5) == 0 ? $urandom_range(1, 5) : $urandom_range(6, 18);
    s = rnd_ws();
    for (int i = 0; i < nf; i++) begin
      if (i == 0 || i == 5) f = rnd_num(0);
      else if (i == 2) f = rnd_flag();
      else if (i == 1 || i >= 6) f = rnd_num(1);
      else f = $urandom_range(0, 1) ? "Rx" : "";
      if ($urandom_range(0, 7) == 0) f = {" ", f};
      s = {s, i ? sep : "", f};
    end
    if ($urandom_range(0, 9) == 0) s = {s, $urandom_range(0, 1) ? "," : "\t"};
    return {s, rnd_ws()};
  endfunction

  task automatic run_until_drained();
    int guard;
    guard = 0;
    while ((text_q.size() != 0 || frames_due.size() != 0) && guard < LIMIT) begin
      @(posedge clk);
      guard++;
    end
  endtask

  initial begin
    clear_line();
    put_text("0,0,0,0,0,0\n");
    put_text("4294967295,FFFFFFFF,TRUE,x,y,8,ff,1,2,3,4,5,6,7\n");
    put_text("99999999999,0x1FFFFFFFFF,true,a,b,9,100,ABC,0XfF,3,4,5,6,7,8\n");
    put_text("  12\t7ff\t1\ta\tb\t3\t11\t22\t33\t44 \t \n");
    put_text("\n   \n");
    put_text("Time,ID,Ext\n");
    put_text("timestamp\tx\n");
    put_text("-5,+7,FALSE,a,b,-3,+1\n");
    put_text("1,2,3,4\n");
    put_text("5,6,1,a,b,4");
    text_q.push_back('{8'd32, 1'b1});
    put_text("1,2,0,3,4,2,, ,zz\n");
    put_text("7,8,T,a,b,5\t\t\n");
    put_text("1,,,,,,,,,,,,,,,,,,,,,,\n");
    put_text("\x80\xff,\x01,");
    text_q.push_back('{8'hFE, 1'b0});
    text_q.push_back('{LF, 1'b1});
    while (text_q.size() < 1400) begin
      put_text(rnd_line());
      text_q.push_back('{$urandom_range(0, 15) == 0 ? 8'd13 : LF, 1'b0});
      if ($urandom_range(0, 15) == 0) text_q[$] = '{LF, 1'b1};
    end
    put_text("Time");
    text_q.push_back('{8'd116, 1'b1});
    run_until_drained();
    calm = 1;
    while (text_q.size() < 300) begin
      put_text(rnd_line());
      text_q.push_back('{LF, 1'b0});
    end
    text_q[$] = '{LF, 1'b1};
    run_until_drained();
    feeding_done = 1;
  end

  int hold_cnt = 0;
  int hold_clk = 0;
  always @(posedge clk) begin
    if (rst_n) hold_clk <= hold_clk + 1;
    if (!calm && hold_cnt == 0 && hold_clk == 800) begin
      hold_off <= 1;
      hold_cnt <= 300;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      if (hold_cnt == 1) hold_off <= 0;
    end
  end

  int src_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_byte(in_tdata, in_tlast);
        void'(text_q.pop_front());
      end
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        in_tvalid <= 0;
      end else if (!calm && !(in_tvalid && !in_tready) && $urandom_range(0, 9) == 0) begin
        src_gap <= $urandom_range(0, 5);
        in_tvalid <= 0;
      end else begin
        text_beat_t b;
        if (text_q.size() > 0) begin
          b = text_q[0];
          in_tvalid <= 1;
          in_tdata <= b.ch;
          in_tlast <= b.last;
        end else in_tvalid <= 0;
      end
    end
  end

  int sink_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        frame_t got, want;
        got = '{out_tuser, out_tdata[31:0], out_tdata[63:32], out_tdata[64],
                out_tdata[68:65], out_tdata[132:69]};
        if (frames_due.size() == 0) begin
          $error("frame with nothing expected");
          failures++;
        end else begin
          want = frames_due.pop_front();
          if (got.err !== want.err) begin
            $error("status exp %0h got %0h", want.err, got.err); failures++; end
          if (got.stamp !== want.stamp) begin
            $error("timestamp exp %0h got %0h", want.stamp, got.stamp); failures++; end
          if (got.ident !== want.ident) begin
            $error("can_id exp %0h got %0h", want.ident, got.ident); failures++; end
          if (got.ext !== want.ext) begin
            $error("extended exp %0h got %0h", want.ext, got.ext); failures++; end
          if (got.len !== want.len) begin
            $error("length exp %0h got %0h", want.len, got.len); failures++; end
          if (got.data !== want.data) begin
            $error("data_bytes exp %0h got %0h", want.data, got.data); failures++; end
          if (out_tdata[135:133] !== 3'b0) begin
            $error("pad exp 0 got %0h", out_tdata[135:133]); failures++; end
        end
      end
      if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        out_tready <= 0;
      end else if (hold_off) out_tready <= 0;
      else if (!calm && $urandom_range(0, 7) == 0) begin
        sink_gap <= $urandom_range(0, 5);
        out_tready <= 0;
      end else out_tready <= 1;
    end
  end

  int cycles = 0;
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1;
    forever begin
      @(posedge clk);
      cycles++;
      if (feeding_done) begin
        repeat (10) @(posedge clk);
        if (failures == 0 && frames_due.size() == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
      end else if (cycles > LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end
endmodule
